// File: sv/bmf_pkg.sv
package bmf_pkg;

    localparam int WINDOW    = 7;
    localparam int MAX_WIDTH = 4096;

    localparam int LINES = WINDOW - 1;
    localparam int HALF  = WINDOW / 2;
    localparam int AREA  = WINDOW * WINDOW;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam int POS_LIMIT   = 4096;
    localparam int WIDTH_LIMIT = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);

    // one line store word holds the previous rows of a column, oldest in the low byte
    localparam int WORD_W   = LINES * PIX_W;
    localparam int COLSUM_W = PIX_W + $clog2(WINDOW);
    localparam int WINSUM_W = $clog2(255 * AREA + 1);

    // truncating divide by AREA as multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT = $clog2(255 * AREA * AREA) + 1;
    localparam int RECIP     = (2 ** DIV_SHIFT) / AREA + 1;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = WINSUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 13'd512;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] crow;
        logic [POS_W-1:0] ccol;
    } bmf_meta_t;

    typedef struct packed {
        logic [PIX_W-1:0] mean_value;
        logic [POS_W-1:0] centre_row;
        logic [POS_W-1:0] centre_col;
        logic             frame_last;
    } bmf_result_t;

endpackage

// File: sv/bmf_ram.sv
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/box_mean_filter_sliding_top.sv
// Channel  Direction  Handshake                  Beat payload
// in       input      in_valid / in_stall        pixel, frame_start
// out      output     out_valid / out_stall      mean_value, centre_row, centre_col, frame_last
// cfg      input      cfg_write                  cfg_index, cfg_data
//
// One pixel per clock while in_stall is low; each result passes stages 1 to 3 and the
// output register. The rate rests on the line store RAM: one read-modify-write of a
// column word per pixel, with the write-back forwarded when the next pixel hits the same column.
// Reset clears position, image size (512 x 512) and handshake state; the line
// store needs no clearing. in_stall rises only while the output skid register is full.
module box_mean_filter_sliding_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bmf_pkg::PIX_W-1:0]     pixel,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bmf_pkg::PIX_W-1:0]     mean_value,
    output logic [bmf_pkg::POS_W-1:0]     centre_row,
    output logic [bmf_pkg::POS_W-1:0]     centre_col,
    output logic                          frame_last,
    input  logic                          cfg_write,
    input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]     cfg_data
);
    import bmf_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_next;
    logic [POS_W-1:0] col_next;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] row_a;
    logic [DIM_W-1:0] col_a;
    logic [DIM_W-1:0] row_b;
    logic [POS_W-1:0] row_cur;
    logic [POS_W-1:0] col_cur;
    logic [DIM_W-1:0] row_inc;
    logic [DIM_W-1:0] col_inc;
    bmf_meta_t        meta_cur;

    logic en;
    logic accept;

    // stage 1: line store word arrives
    logic             s1_valid_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    bmf_meta_t        s1_meta_reg;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] word_cur;
    logic [WORD_W-1:0] word_new;
    logic [COLSUM_W-1:0] colsum;

    logic              fwd_valid_reg;
    logic [POS_W-1:0]  fwd_col_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    // stage 2: column sum
    logic                s2_valid_reg;
    logic [COLSUM_W-1:0] s2_colsum_reg;
    bmf_meta_t           s2_meta_reg;
    logic [COLSUM_W-1:0] hist_reg [LINES];
    logic [WINSUM_W-1:0] winsum;

    // stage 3: window sum
    logic                s3_valid_reg;
    logic [WINSUM_W-1:0] s3_winsum_reg;
    bmf_meta_t           s3_meta_reg;
    logic [PROD_W-1:0]   product;
    bmf_result_t         res_cur;

    bmf_result_t out_reg;
    logic        out_valid_reg;
    bmf_result_t skid_reg;
    logic        skid_valid_reg;
    logic        out_load;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(WIDTH_LIMIT))
            w_eff = DIM_W'(WIDTH_LIMIT);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(POS_LIMIT))
            h_eff = DIM_W'(POS_LIMIT);
        else
            h_eff = height_reg;

        row_a = frame_start ? '0 : {1'b0, row_reg};
        col_a = frame_start ? '0 : {1'b0, col_reg};

        // wrap a position left out of range by a lowered register
        if (col_a >= w_eff)
        begin
            col_a = '0;
            row_b = row_a + DIM_W'(1);
        end
        else
        begin
            row_b = row_a;
        end
        if (row_b >= h_eff)
            row_b = '0;

        row_cur = row_b[POS_W-1:0];
        col_cur = col_a[POS_W-1:0];

        row_inc = {1'b0, row_cur} + DIM_W'(1);
        col_inc = {1'b0, col_cur} + DIM_W'(1);

        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
        end
        else
        begin
            col_next = col_inc[POS_W-1:0];
            row_next = row_cur;
        end

        meta_cur.emit = (row_cur >= POS_W'(LINES)) && (col_cur >= POS_W'(LINES));
        meta_cur.last = (row_inc >= h_eff) && (col_inc >= w_eff);
        meta_cur.crow = row_cur - POS_W'(HALF);
        meta_cur.ccol = col_cur - POS_W'(HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    bmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .wen   (en && s1_valid_reg),
        .waddr (ADDR_W'(s1_col_reg)),
        .wdata (word_new),
        .ren   (accept),
        .raddr (ADDR_W'(col_cur)),
        .rdata (ram_rdata)
    );

    // take the word written back at the edge of our own read when the column matches
    always_comb
    begin
        word_cur = (fwd_valid_reg && (fwd_col_reg == s1_col_reg)) ? fwd_word_reg : ram_rdata;
        colsum   = COLSUM_W'(s1_pix_reg);
        for (int k = 0; k < LINES; k++)
        begin
            colsum = colsum + COLSUM_W'(word_cur[k*PIX_W +: PIX_W]);
        end
        word_new = {s1_pix_reg, word_cur[WORD_W-1:PIX_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            fwd_valid_reg <= s1_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_meta_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg   <= col_cur;
            s1_pix_reg   <= pixel;
            s1_meta_reg  <= meta_cur;
            fwd_col_reg  <= s1_col_reg;
            fwd_word_reg <= word_new;
            s2_colsum_reg <= colsum;
            s2_meta_reg   <= s1_meta_reg;
            s3_winsum_reg <= winsum;
            s3_meta_reg   <= s2_meta_reg;
            if (s2_valid_reg)
            begin
                for (int k = 0; k + 1 < LINES; k++)
                begin
                    hist_reg[k] <= hist_reg[k+1];
                end
                hist_reg[LINES-1] <= s2_colsum_reg;
            end
        end
    end

    always_comb
    begin
        winsum = WINSUM_W'(s2_colsum_reg);
        for (int k = 0; k < LINES; k++)
        begin
            winsum = winsum + WINSUM_W'(hist_reg[k]);
        end
    end

    assign product = PROD_W'(s3_winsum_reg) * PROD_W'(RECIP);

    always_comb
    begin
        res_cur.mean_value = product[DIV_SHIFT +: PIX_W];
        res_cur.centre_row = s3_meta_reg.crow;
        res_cur.centre_col = s3_meta_reg.ccol;
        res_cur.frame_last = s3_meta_reg.last;
    end

    assign out_load = !out_valid_reg || !out_stall;

    // hold a beat in the skid register while the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
        else if (s3_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_cur;
        end
        else if (en && s3_valid_reg)
        begin
            skid_reg <= res_cur;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_value = out_reg.mean_value;
    assign centre_row = out_reg.centre_row;
    assign centre_col = out_reg.centre_col;
    assign frame_last = out_reg.frame_last;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bmf_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 650;
    localparam int CFG_MAX       = (1 << CFG_W) - 1;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_MAX,
        STYLE_ZERO,
        STYLE_CHECKER
    } pix_style_e;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel;
    logic                 frame_start;
    logic                 out_valid;
    logic                 out_stall;
    logic [PIX_W-1:0]     mean_value;
    logic [POS_W-1:0]     centre_row;
    logic [POS_W-1:0]     centre_col;
    logic                 frame_last;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // own copy of the filter state
    bit [PIX_W-1:0]    line_hist [LINES][MAX_WIDTH];
    bit [COLSUM_W-1:0] col_sums [WINDOW];
    logic [POS_W-1:0]  row_pos;
    logic [POS_W-1:0]  col_pos;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;

    bmf_result_t pending_means [$];
    int          mismatch_count;
    int          pixels_sent;
    int          send_idle_pct;
    int          stall_pct;
    logic        hold_off;
    logic        restart_pending;

    box_mean_filter_sliding_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean_value  (mean_value),
        .centre_row  (centre_row),
        .centre_col  (centre_col),
        .frame_last  (frame_last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int dim_limit(input logic [CFG_W-1:0] value, input int hi);
        int d;
        d = int'(value);
        if (d < 1) d = 1;
        if (d > hi) d = hi;
        return d;
    endfunction

    function automatic void smooth_pixel(input logic [PIX_W-1:0] p, input logic fs);
        int w;
        int h;
        int r;
        int c;
        int k;
        int colsum;
        int winsum;
        bmf_result_t res;
        w = dim_limit(width_reg, WIDTH_LIMIT);
        h = dim_limit(height_reg, POS_LIMIT);
        r = int'(row_pos);
        c = int'(col_pos);
        if (fs)
        begin
            r = 0;
            c = 0;
        end
        // a position left beyond a lowered size wraps like an ordinary row end
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;

        colsum = int'(p);
        for (k = 0; k < LINES; k++)
            colsum += int'(line_hist[k][c]);
        for (k = 0; k + 1 < LINES; k++)
            line_hist[k][c] = line_hist[k + 1][c];
        line_hist[LINES - 1][c] = p;

        winsum = colsum;
        for (k = 0; k + 1 < WINDOW; k++)
        begin
            col_sums[k] = col_sums[k + 1];
            winsum += int'(col_sums[k]);
        end
        col_sums[WINDOW - 1] = COLSUM_W'(colsum);

        if (r >= LINES && c >= LINES)
        begin
            res.mean_value = PIX_W'(winsum / AREA);
            res.centre_row = POS_W'(r - HALF);
            res.centre_col = POS_W'(c - HALF);
            res.frame_last = (r + 1 >= h) && (c + 1 >= w);
            pending_means.push_back(res);
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = POS_W'(r);
        col_pos = POS_W'(c);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        bmf_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
                report_mismatch("unexpected beat, centre_col", 32'(centre_col), 0);
            else
            begin
                want = pending_means.pop_front();
                if (mean_value !== want.mean_value)
                    report_mismatch("mean_value", 32'(mean_value), 32'(want.mean_value));
                if (centre_row !== want.centre_row)
                    report_mismatch("centre_row", 32'(centre_row), 32'(want.centre_row));
                if (centre_col !== want.centre_col)
                    report_mismatch("centre_col", 32'(centre_col), 32'(want.centre_col));
                if (frame_last !== want.frame_last)
                    report_mismatch("frame_last", 32'(frame_last), 32'(want.frame_last));
            end
        end
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs);
        logic fs_eff;
        // a wider row than before leaves columns unwritten: force a fresh frame
        fs_eff          = fs | restart_pending;
        restart_pending = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= p;
        frame_start <= fs_eff;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        smooth_pixel(p, fs_eff);
        pixels_sent++;
    endtask

    task automatic send_run(input int w, input int count, input bit fresh,
                            input pix_style_e style, input bit noisy);
        int n;
        logic [PIX_W-1:0] p;
        logic fs;
        for (n = 0; n < count; n++)
        begin
            case (style)
                STYLE_MAX:     p = '1;
                STYLE_ZERO:    p = '0;
                STYLE_CHECKER: p = ((n % w + n / w) % 2 != 0) ? '1 : '0;
                default:       p = PIX_W'($urandom_range(255));
            endcase
            fs = (n == 0) && fresh;
            if (noisy && $urandom_range(149) == 0) fs = 1'b1;
            send_pixel(p, fs);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        int old_w;
        old_w = dim_limit(width_reg, WIDTH_LIMIT);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = CFG_W'(value);
        else
            height_reg = CFG_W'(value);
        if (dim_limit(width_reg, WIDTH_LIMIT) > old_w) restart_pending = 1'b1;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_register_limits();
        settle();
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        send_run(1, 4, 1'b1, STYLE_RANDOM, 1'b0);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_MAX);
        write_reg(REG_IMAGE_HEIGHT, CFG_MAX);
        send_run(WIDTH_LIMIT, 5, 1'b1, STYLE_MAX, 1'b0);
    endtask

    task automatic test_small_image();
        settle();
        write_reg(REG_IMAGE_WIDTH, WINDOW - 1);
        write_reg(REG_IMAGE_HEIGHT, WINDOW);
        send_run(WINDOW - 1, (WINDOW - 1) * WINDOW, 1'b1, STYLE_RANDOM, 1'b0);
        settle();
        write_reg(REG_IMAGE_WIDTH, WINDOW);
        write_reg(REG_IMAGE_HEIGHT, WINDOW - 1);
        send_run(WINDOW, WINDOW * (WINDOW - 1), 1'b1, STYLE_RANDOM, 1'b0);
    endtask

    task automatic test_extreme_pixels();
        settle();
        write_reg(REG_IMAGE_WIDTH, WINDOW);
        write_reg(REG_IMAGE_HEIGHT, WINDOW);
        send_run(WINDOW, AREA, 1'b1, STYLE_MAX, 1'b0);
        // no frame_start here: the row wraps after the last row on its own
        send_run(WINDOW, AREA, 1'b0, STYLE_ZERO, 1'b0);
        send_run(WINDOW, AREA, 1'b1, STYLE_CHECKER, 1'b0);
    endtask

    task automatic test_lowered_limits();
        settle();
        write_reg(REG_IMAGE_WIDTH, 12);
        write_reg(REG_IMAGE_HEIGHT, 12);
        send_run(12, 8 * 12 + 10, 1'b1, STYLE_RANDOM, 1'b0);
        settle();
        write_reg(REG_IMAGE_WIDTH, 8);
        send_run(8, 2 * 8, 1'b0, STYLE_RANDOM, 1'b0);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 9);
        send_run(8, 8 * 9, 1'b0, STYLE_RANDOM, 1'b0);
    endtask

    task automatic test_back_pressure();
        settle();
        set_idling(0, 0);
        write_reg(REG_IMAGE_WIDTH, 12);
        write_reg(REG_IMAGE_HEIGHT, 9);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        send_run(12, 12 * 9, 1'b1, STYLE_RANDOM, 1'b0);
    endtask

    task automatic test_widest_row();
        settle();
        set_idling(0, 0);
        write_reg(REG_IMAGE_WIDTH, CFG_MAX);
        write_reg(REG_IMAGE_HEIGHT, WINDOW);
        send_run(WIDTH_LIMIT, 64, 1'b1, STYLE_RANDOM, 1'b0);
    endtask

    task automatic test_tallest_column();
        settle();
        write_reg(REG_IMAGE_WIDTH, WINDOW);
        write_reg(REG_IMAGE_HEIGHT, POS_LIMIT);
        send_run(WINDOW, WINDOW * 12, 1'b1, STYLE_RANDOM, 1'b0);
    endtask

    task automatic test_random_frames();
        int first_count;
        int iter;
        int w;
        int h;
        pix_style_e style;
        first_count = pixels_sent;
        iter        = 0;
        while (pixels_sent - first_count < RANDOM_ITEMS)
        begin
            settle();
            case (iter % 4)
                0: set_idling(0, 0);
                1: set_idling(58, 0);
                2: set_idling(0, 58);
                default: set_idling(30, 30);
            endcase
            w = ($urandom_range(5) == 0) ? $urandom_range(1, WINDOW - 1)
                                         : $urandom_range(WINDOW, 16);
            h = ($urandom_range(5) == 0) ? $urandom_range(1, WINDOW - 1)
                                         : $urandom_range(WINDOW, 10);
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            repeat ($urandom_range(1, 2))
            begin
                style = ($urandom_range(7) == 0) ? pix_style_e'($urandom_range(1, 3))
                                                 : STYLE_RANDOM;
                // mostly whole frames; now and then a cut-off or unmarked one
                if ($urandom_range(9) == 0)
                    send_run(w, $urandom_range(1, w * h), $urandom_range(1), style, 1'b1);
                else
                    send_run(w, w * h, 1'b1, style, $urandom_range(3) == 0);
            end
            iter++;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        pixel           = '0;
        frame_start     = 1'b0;
        out_stall       = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_IMAGE_WIDTH;
        cfg_data        = '0;
        hold_off        = 1'b0;
        restart_pending = 1'b0;
        mismatch_count  = 0;
        pixels_sent     = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        width_reg       = DIM_RESET;
        height_reg      = DIM_RESET;
        row_pos         = '0;
        col_pos         = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_limits();
        test_small_image();
        test_extreme_pixels();
        test_lowered_limits();
        test_back_pressure();
        test_widest_row();
        test_tallest_column();
        test_random_frames();
        settle();

        if (mismatch_count == 0)
            $display("PASS box_mean_filter_sliding_top");
        else
            $display("FAIL box_mean_filter_sliding_top");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL box_mean_filter_sliding_top");
        $finish;
    end

endmodule

// File: box_mean_filter_sliding_top.f
sv/bmf_pkg.sv
sv/bmf_ram.sv
sv/box_mean_filter_sliding_top.sv
sim/testbench.sv
